// File: design/rzsa_pkg.sv
`timescale 1ns / 1ps
// Shared types, register codes, angle folding and sine table generation for the rotozoom address block.
package rzsa_pkg;

    localparam int ANGLE_BITS     = 10;
    localparam int ANGLE_RED_BITS = 9;
    localparam int ZOOM_BITS      = 17;
    localparam int CFG_INDEX_BITS = 3;
    localparam int TAB_INDEX_BITS = 7;
    localparam int TAB_DEPTH      = 128;
    localparam int QUARTER_DEG    = 90;

    localparam logic [63:0] PI_Q32 = 64'd13493037705;

    localparam logic [ZOOM_BITS-1:0]  ZOOM_RESET  = 17'd65536;
    localparam logic [ANGLE_BITS-1:0] ANGLE_RESET = 10'd0;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ANGLE  = 3'd0,
        CFG_ZOOM_X = 3'd1,
        CFG_ZOOM_Y = 3'd2,
        CFG_HALF_W = 3'd3,
        CFG_HALF_H = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic                      neg;
        logic [TAB_INDEX_BITS-1:0] k;
    } fold_t;

    typedef struct packed {
        logic ovf;
        logic pos;
    } lane_flags_t;

    // Folds an angle of 0 to 359 degrees onto the first quadrant of the sine.
    function automatic fold_t fold_angle(input logic [ANGLE_RED_BITS-1:0] a);
        fold_t f;
        f.neg = 1'b0;
        if (a <= 9'd90) begin
            f.k = a[TAB_INDEX_BITS-1:0];
        end else if (a <= 9'd180) begin
            f.k = TAB_INDEX_BITS'(9'd180 - a);
        end else if (a <= 9'd270) begin
            f.k   = TAB_INDEX_BITS'(a - 9'd180);
            f.neg = 1'b1;
        end else begin
            f.k   = TAB_INDEX_BITS'(9'd360 - a);
            f.neg = 1'b1;
        end
        return f;
    endfunction

    // Sine of k degrees in Q30 from an eleven-term series; evaluated at elaboration only.
    function automatic logic [63:0] quarter_sine_q30(input int k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        int          kk;
        kk = (k > QUARTER_DEG) ? QUARTER_DEG : ((k < 0) ? 0 : k);
        x    = (PI_Q32 * 64'(kk) / 180 + 64'd2) >> 2;
        x2   = (x * x) >> 30;
        acc  = x;
        term = x;
        term = ((term * x2) >> 30) / 6;   acc = acc - term;
        term = ((term * x2) >> 30) / 20;  acc = acc + term;
        term = ((term * x2) >> 30) / 42;  acc = acc - term;
        term = ((term * x2) >> 30) / 72;  acc = acc + term;
        term = ((term * x2) >> 30) / 110; acc = acc - term;
        term = ((term * x2) >> 30) / 156; acc = acc + term;
        term = ((term * x2) >> 30) / 210; acc = acc - term;
        term = ((term * x2) >> 30) / 272; acc = acc + term;
        term = ((term * x2) >> 30) / 342; acc = acc - term;
        term = ((term * x2) >> 30) / 420; acc = acc + term;
        return acc;
    endfunction

endpackage

// File: design/rotate_zoom_source_address.sv
`timescale 1ns / 1ps
// Top level of the rotozoom source address generator.
//
// Channel   Dir   Handshake             Contents
// s_        in    s_tvalid / s_tready   s_tdata: dest_x, dest_y
// m_        out   m_tvalid / m_tready   m_tdata: source_x, source_y; m_tuser: inside_res
// cfg_      in    cfg_valid / cfg_ready cfg_index, cfg_data (register write)
//
// One transfer is accepted per cycle while the skid stage is empty.
// The pipeline is six front stages, a range check plus one divider stage per quotient bit,
// and the output register.
// Reset is synchronous and active low and loads the register defaults.
// A stalled output fills the skid stage, then the whole pipeline holds until it drains.
module rotate_zoom_source_address #(
    parameter int COORD_BITS     = 10,
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]        s_tdata,   // dest_x, dest_y
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output logic [((2*COORD_BITS+7)/8)*8-1:0]        m_tdata,   // source_x, source_y
    output logic                                     m_tuser,   // inside_res
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [rzsa_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  logic [rzsa_pkg::ZOOM_BITS-1:0]           cfg_data
);
    import rzsa_pkg::*;

    localparam int DW = COORD_BITS + ZOOM_BITS;

    logic [ANGLE_BITS-1:0] angle_reg, angle_next;
    logic [ZOOM_BITS-1:0]  zoom_x_reg, zoom_x_next, zoom_y_reg, zoom_y_next;
    logic [COORD_BITS-1:0] half_w_reg, half_w_next, half_h_reg, half_h_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        angle_next  = angle_reg;
        zoom_x_next = zoom_x_reg;
        zoom_y_next = zoom_y_reg;
        half_w_next = half_w_reg;
        half_h_next = half_h_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_ANGLE:  angle_next  = cfg_data[ANGLE_BITS-1:0];
                CFG_ZOOM_X: zoom_x_next = cfg_data;
                CFG_ZOOM_Y: zoom_y_next = cfg_data;
                CFG_HALF_W: half_w_next = cfg_data[COORD_BITS-1:0];
                CFG_HALF_H: half_h_next = cfg_data[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_reg  <= ANGLE_RESET;
            zoom_x_reg <= ZOOM_RESET;
            zoom_y_reg <= ZOOM_RESET;
            half_w_reg <= COORD_BITS'(320);
            half_h_reg <= COORD_BITS'(240);
        end else begin
            angle_reg  <= angle_next;
            zoom_x_reg <= zoom_x_next;
            zoom_y_reg <= zoom_y_next;
            half_w_reg <= half_w_next;
            half_h_reg <= half_h_next;
        end
    end

    logic                  pipe_en;
    logic                  front_valid, pos_x, pos_y;
    logic [DW-1:0]         mag_x, mag_y;
    logic                  div_valid_x, div_valid_y;
    logic [COORD_BITS-1:0] quo_x, quo_y;
    lane_flags_t           flags_x, flags_y;
    logic [COORD_BITS-1:0] source_x, source_y;

    assign s_tready = pipe_en;

    rzsa_front #(
        .COORD_BITS     (COORD_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (pipe_en),
        .in_valid    (s_tvalid),
        .dest_x      (s_tdata[COORD_BITS-1:0]),
        .dest_y      (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .angle_deg   (angle_reg),
        .half_width  (half_w_reg),
        .half_height (half_h_reg),
        .out_valid   (front_valid),
        .mag_x       (mag_x),
        .mag_y       (mag_y),
        .pos_x       (pos_x),
        .pos_y       (pos_y)
    );

    rzsa_divider #(
        .QW (COORD_BITS),
        .DW (DW)
    ) u_div_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (front_valid),
        .dividend  (mag_x),
        .divisor   (zoom_x_reg),
        .in_pos    (pos_x),
        .out_valid (div_valid_x),
        .quotient  (quo_x),
        .out_flags (flags_x)
    );

    rzsa_divider #(
        .QW (COORD_BITS),
        .DW (DW)
    ) u_div_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (front_valid),
        .dividend  (mag_y),
        .divisor   (zoom_y_reg),
        .in_pos    (pos_y),
        .out_valid (div_valid_y),
        .quotient  (quo_y),
        .out_flags (flags_y)
    );

    rzsa_output #(
        .COORD_BITS (COORD_BITS)
    ) u_output (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (div_valid_x && div_valid_y),
        .in_ready    (pipe_en),
        .quo_x       (quo_x),
        .quo_y       (quo_y),
        .flags_x     (flags_x),
        .flags_y     (flags_y),
        .half_width  (half_w_reg),
        .half_height (half_h_reg),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .source_x    (source_x),
        .source_y    (source_y),
        .inside_res  (m_tuser)
    );

    always_comb begin
        m_tdata                               = '0;
        m_tdata[COORD_BITS-1:0]               = source_x;
        m_tdata[2*COORD_BITS-1:COORD_BITS]    = source_y;
    end

endmodule

// File: design/rzsa_front.sv
`timescale 1ns / 1ps
// Front pipeline: centre offsets, angle reduction, sine and cosine lookup, rotation products and magnitudes.
module rzsa_front #(
    parameter int COORD_BITS     = 10,
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    en,
    input  logic                                    in_valid,
    input  logic [COORD_BITS-1:0]                   dest_x,
    input  logic [COORD_BITS-1:0]                   dest_y,
    input  logic [rzsa_pkg::ANGLE_BITS-1:0]         angle_deg,
    input  logic [COORD_BITS-1:0]                   half_width,
    input  logic [COORD_BITS-1:0]                   half_height,
    output logic                                    out_valid,
    output logic [COORD_BITS+rzsa_pkg::ZOOM_BITS-1:0] mag_x,
    output logic [COORD_BITS+rzsa_pkg::ZOOM_BITS-1:0] mag_y,
    output logic                                    pos_x,
    output logic                                    pos_y
);
    import rzsa_pkg::*;

    localparam int JW = COORD_BITS + 1;
    localparam int SW = TRIG_FRAC_BITS + 2;
    localparam int PW = JW + SW;
    localparam int NW = PW + 1;
    localparam int DW = COORD_BITS + ZOOM_BITS;

    // The zoom is Q1.16, so the magnitude is rescaled from the sine format to the zoom format.
    localparam int ZOOM_FRAC = ZOOM_BITS - 1;
    localparam int MAG_SHL   = (TRIG_FRAC_BITS < ZOOM_FRAC) ? ZOOM_FRAC - TRIG_FRAC_BITS : 0;
    localparam int MAG_SHR   = (TRIG_FRAC_BITS > ZOOM_FRAC) ? TRIG_FRAC_BITS - ZOOM_FRAC : 0;
    localparam int AW        = NW + MAG_SHL;

    logic [TRIG_FRAC_BITS:0] sine_tab [0:TAB_DEPTH-1];

    for (genvar g = 0; g < TAB_DEPTH; g++) begin : g_tab
        localparam logic [63:0] Q30   = quarter_sine_q30(g);
        localparam logic [63:0] ENTRY = (Q30 + (64'd1 << (29 - TRIG_FRAC_BITS)))
                                        >> (30 - TRIG_FRAC_BITS);
        assign sine_tab[g] = ENTRY[TRIG_FRAC_BITS:0];
    end

    // Stage 1: offsets from the centre and the reduced sine and cosine angles.
    logic                     v1_reg;
    logic signed [JW-1:0]     j1_reg, i1_reg, j1_next, i1_next;
    logic [ANGLE_RED_BITS-1:0] as1_reg, ac1_reg, as1_next, ac1_next;
    logic signed [10:0]       deg_ext, a_red;
    logic [9:0]               a_plus;

    always_comb begin
        j1_next = $signed({1'b0, dest_x}) - $signed({1'b0, half_width});
        i1_next = $signed({1'b0, dest_y}) - $signed({1'b0, half_height});
        deg_ext = $signed({angle_deg[ANGLE_BITS-1], angle_deg});
        if (deg_ext < -11'sd360) begin
            a_red = deg_ext + 11'sd720;
        end else if (deg_ext < 11'sd0) begin
            a_red = deg_ext + 11'sd360;
        end else if (deg_ext >= 11'sd360) begin
            a_red = deg_ext - 11'sd360;
        end else begin
            a_red = deg_ext;
        end
        as1_next = a_red[ANGLE_RED_BITS-1:0];
        a_plus   = {1'b0, as1_next} + 10'd90;
        ac1_next = (a_plus >= 10'd360) ? ANGLE_RED_BITS'(a_plus - 10'd360)
                                       : a_plus[ANGLE_RED_BITS-1:0];
    end

    // Stage 2: quadrant folding.
    logic                 v2_reg;
    logic signed [JW-1:0] j2_reg, i2_reg;
    fold_t                fs2_reg, fc2_reg;

    // Stage 3: signed sine and cosine.
    logic                 v3_reg;
    logic signed [JW-1:0] j3_reg, i3_reg;
    logic signed [SW-1:0] s3_reg, c3_reg, s3_next, c3_next;

    always_comb begin
        s3_next = $signed({1'b0, sine_tab[fs2_reg.k]});
        c3_next = $signed({1'b0, sine_tab[fc2_reg.k]});
        if (fs2_reg.neg) begin
            s3_next = -s3_next;
        end
        if (fc2_reg.neg) begin
            c3_next = -c3_next;
        end
    end

    // Stage 4: rotation products.
    logic                 v4_reg;
    logic signed [PW-1:0] js4_reg, ic4_reg, jc4_reg, is4_reg;

    // Stage 5: rotated numerators.
    logic                 v5_reg;
    logic [NW-1:0]        ny5_reg, nx5_reg, ny5_next, nx5_next;

    always_comb begin
        ny5_next = {js4_reg[PW-1], js4_reg} + {ic4_reg[PW-1], ic4_reg};
        nx5_next = {jc4_reg[PW-1], jc4_reg} - {is4_reg[PW-1], is4_reg};
    end

    // Stage 6: rescaled magnitudes and sign flags.
    logic          v6_reg;
    logic [DW-1:0] mx6_reg, my6_reg, mx6_next, my6_next;
    logic          px6_reg, py6_reg, px6_next, py6_next;
    logic [NW-1:0] abs_x, abs_y;
    logic [AW-1:0] wide_x, wide_y;

    always_comb begin
        abs_x    = nx5_reg[NW-1] ? (~nx5_reg + 1'b1) : nx5_reg;
        abs_y    = ny5_reg[NW-1] ? (~ny5_reg + 1'b1) : ny5_reg;
        wide_x   = (AW'(abs_x) << MAG_SHL) >> MAG_SHR;
        wide_y   = (AW'(abs_y) << MAG_SHL) >> MAG_SHR;
        mx6_next = wide_x[DW-1:0];
        my6_next = wide_y[DW-1:0];
        px6_next = !nx5_reg[NW-1] && (nx5_reg != '0);
        py6_next = !ny5_reg[NW-1] && (ny5_reg != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            j1_reg  <= j1_next;
            i1_reg  <= i1_next;
            as1_reg <= as1_next;
            ac1_reg <= ac1_next;
            j2_reg  <= j1_reg;
            i2_reg  <= i1_reg;
            fs2_reg <= fold_angle(as1_reg);
            fc2_reg <= fold_angle(ac1_reg);
            j3_reg  <= j2_reg;
            i3_reg  <= i2_reg;
            s3_reg  <= s3_next;
            c3_reg  <= c3_next;
            js4_reg <= j3_reg * s3_reg;
            ic4_reg <= i3_reg * c3_reg;
            jc4_reg <= j3_reg * c3_reg;
            is4_reg <= i3_reg * s3_reg;
            ny5_reg <= ny5_next;
            nx5_reg <= nx5_next;
            mx6_reg <= mx6_next;
            my6_reg <= my6_next;
            px6_reg <= px6_next;
            py6_reg <= py6_next;
        end
    end

    assign out_valid = v6_reg;
    assign mag_x     = mx6_reg;
    assign mag_y     = my6_reg;
    assign pos_x     = px6_reg;
    assign pos_y     = py6_reg;

endmodule

// File: design/rzsa_divider.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: range check, then one quotient bit per stage.
module rzsa_divider #(
    parameter int QW = 10,
    parameter int DW = 27
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [DW-1:0]                  dividend,
    input  logic [rzsa_pkg::ZOOM_BITS-1:0] divisor,
    input  logic                           in_pos,
    output logic                           out_valid,
    output logic [QW-1:0]                  quotient,
    output rzsa_pkg::lane_flags_t          out_flags
);
    import rzsa_pkg::*;

    localparam int CW = (DW > QW + ZOOM_BITS) ? DW : QW + ZOOM_BITS;

    logic              valid_reg [0:QW];
    logic [DW-1:0]     rem_reg   [0:QW];
    logic [QW-1:0]     quo_reg   [0:QW];
    lane_flags_t       flags_reg [0:QW];

    // A quotient that needs more than QW bits, or a zero divisor, is flagged out of range.
    logic [CW-1:0] div_top;
    lane_flags_t   flags0_next;

    always_comb begin
        div_top         = CW'(divisor) << QW;
        flags0_next.pos = in_pos;
        flags0_next.ovf = (CW'(dividend) >= div_top);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]   <= dividend;
            quo_reg[0]   <= '0;
            flags_reg[0] <= flags0_next;
        end
    end

    for (genvar t = 0; t < QW; t++) begin : g_stage
        localparam int B = QW - 1 - t;

        logic [CW-1:0] shifted;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] quo_next;

        always_comb begin
            shifted  = CW'(divisor) << B;
            ge       = (CW'(rem_reg[t]) >= shifted);
            rem_next = ge ? (rem_reg[t] - shifted[DW-1:0]) : rem_reg[t];
            quo_next = {quo_reg[t][QW-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[t+1] <= 1'b0;
            end else if (en) begin
                valid_reg[t+1] <= valid_reg[t];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[t+1]   <= rem_next;
                quo_reg[t+1]   <= quo_next;
                flags_reg[t+1] <= flags_reg[t];
            end
        end
    end

    assign out_valid = valid_reg[QW];
    assign quotient  = quo_reg[QW];
    assign out_flags = flags_reg[QW];

endmodule

// File: design/rzsa_output.sv
`timescale 1ns / 1ps
// Final rounding and range test, output register and skid buffer.
module rzsa_output #(
    parameter int COORD_BITS = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_BITS-1:0] quo_x,
    input  logic [COORD_BITS-1:0] quo_y,
    input  rzsa_pkg::lane_flags_t flags_x,
    input  rzsa_pkg::lane_flags_t flags_y,
    input  logic [COORD_BITS-1:0] half_width,
    input  logic [COORD_BITS-1:0] half_height,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COORD_BITS-1:0] source_x,
    output logic [COORD_BITS-1:0] source_y,
    output logic                  inside_res
);
    import rzsa_pkg::*;

    localparam int RW = 2 * COORD_BITS + 1;

    logic [COORD_BITS-1:0] sx, sy;
    logic                  in_x, in_y, src_in;
    logic [RW-1:0]         res;

    // Positive values truncate; others give minus the quotient minus one.
    always_comb begin
        in_x   = !flags_x.ovf && (quo_x < half_width);
        in_y   = !flags_y.ovf && (quo_y < half_height);
        src_in = in_x && in_y;
        sx     = flags_x.pos ? (half_width + quo_x) : (half_width - quo_x - 1'b1);
        sy     = flags_y.pos ? (half_height + quo_y) : (half_height - quo_y - 1'b1);
        if (!src_in) begin
            sx = '0;
            sy = '0;
        end
        res = {src_in, sy, sx};
    end

    logic          out_valid_reg, out_valid_next;
    logic          skid_valid_reg, skid_valid_next;
    logic [RW-1:0] out_data_reg, out_data_next;
    logic [RW-1:0] skid_data_reg, skid_data_next;
    logic          take;

    assign in_ready = !skid_valid_reg;
    assign take     = in_valid && in_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (take) begin
            if (out_valid_reg && !m_ready) begin
                skid_valid_next = 1'b1;
                skid_data_next  = res;
            end else begin
                out_valid_next = 1'b1;
                out_data_next  = res;
            end
        end else if (m_ready) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid    = out_valid_reg;
    assign source_x   = out_data_reg[COORD_BITS-1:0];
    assign source_y   = out_data_reg[2*COORD_BITS-1:COORD_BITS];
    assign inside_res = out_data_reg[RW-1];

endmodule

// File: design/rzsa_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the rotozoom source address generator and their binding.
module rzsa_checker #(
    parameter int COORD_BITS = 10
) (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,
    input logic                              m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed or vanished while stalled");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("pipeline not empty and ready after reset");

    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[2*COORD_BITS-1:0] == '0)
        else $error("source coordinates not zero for an outside result");

    a_busy_has_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input held off with no result pending");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("input held off without an output stall");

endmodule

bind rotate_zoom_source_address rzsa_checker #(
    .COORD_BITS (COORD_BITS)
) u_rzsa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: tb/sv/rotate_zoom_source_address_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the rotozoom source address generator, with a scoreboard class.
module rotate_zoom_source_address_tb;
    import rzsa_pkg::*;

    localparam int COORD_BITS     = 10;
    localparam int TRIG_FRAC_BITS = 15;
    localparam int DATA_W         = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int LATENCY        = COORD_BITS + 8;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int RANDOM_PHASES  = 24;
    localparam int PHASE_ITEMS    = 80;

    class rotozoom_scoreboard;
        typedef struct {
            logic [COORD_BITS-1:0] sx;
            logic [COORD_BITS-1:0] sy;
            logic                  in_image;
        } source_t;

        logic signed [ANGLE_BITS-1:0] angle;
        logic [ZOOM_BITS-1:0]         zoom_x;
        logic [ZOOM_BITS-1:0]         zoom_y;
        logic [COORD_BITS-1:0]        half_w;
        logic [COORD_BITS-1:0]        half_h;
        longint                       sine_q15[0:90];
        source_t                      pending_sources[$];
        int                           errors;
        int                           checked;
        int                           inside_seen;

        function new();
            longint unsigned x;
            longint unsigned x2;
            longint unsigned term;
            longint unsigned acc;
            longint unsigned kk;
            longint unsigned div;
            for (int k = 0; k <= 90; k++) begin
                kk   = k;
                x    = (PI_Q32 * kk / 180 + 64'd2) >> 2;
                x2   = (x * x) >> 30;
                acc  = x;
                term = x;
                for (int n = 1; n <= 10; n++) begin
                    div  = (2 * n) * (2 * n + 1);
                    term = ((term * x2) >> 30) / div;
                    if (n % 2 == 1) begin
                        acc = acc - term;
                    end else begin
                        acc = acc + term;
                    end
                end
                sine_q15[k] = longint'((acc + (64'd1 << (29 - TRIG_FRAC_BITS)))
                                       >> (30 - TRIG_FRAC_BITS));
            end
            angle  = ANGLE_RESET;
            zoom_x = ZOOM_RESET;
            zoom_y = ZOOM_RESET;
            half_w = COORD_BITS'(320);
            half_h = COORD_BITS'(240);
            errors = 0;
            checked = 0;
            inside_seen = 0;
        endfunction

        function void set_register(cfg_reg_t idx, logic [ZOOM_BITS-1:0] data);
            case (idx)
                CFG_ANGLE:  angle  = data[ANGLE_BITS-1:0];
                CFG_ZOOM_X: zoom_x = data;
                CFG_ZOOM_Y: zoom_y = data;
                CFG_HALF_W: half_w = data[COORD_BITS-1:0];
                CFG_HALF_H: half_h = data[COORD_BITS-1:0];
                default: ;
            endcase
        endfunction

        function longint sine_deg(int a);
            if (a <= 90) return sine_q15[a];
            if (a <= 180) return sine_q15[180 - a];
            if (a <= 270) return -sine_q15[a - 180];
            return -sine_q15[360 - a];
        endfunction

        // Floors positive quotients; anything else gives the truncated quotient minus one.
        function longint scaled_offset(longint num, logic [ZOOM_BITS-1:0] zoom);
            longint den;
            den = longint'(zoom) << TRIG_FRAC_BITS;
            if (num > 0) return (num << 16) / den;
            return -(((-num) << 16) / den) - 1;
        endfunction

        function void add_destination(logic [COORD_BITS-1:0] dx, logic [COORD_BITS-1:0] dy);
            int      deg;
            int      a;
            longint  s;
            longint  c;
            longint  xs;
            longint  ys;
            longint  j;
            longint  i;
            longint  m;
            longint  n;
            source_t e;
            deg = angle;
            a   = ((deg % 360) + 360) % 360;
            s   = sine_deg(a);
            c   = sine_deg((a + 90) % 360);
            xs  = half_w;
            ys  = half_h;
            j   = longint'(dx) - xs;
            i   = longint'(dy) - ys;
            e.sx = '0;
            e.sy = '0;
            e.in_image = 1'b0;
            if (zoom_x != 0 && zoom_y != 0) begin
                m = scaled_offset(j * s + i * c, zoom_y);
                n = scaled_offset(j * c - i * s, zoom_x);
                if (m >= -ys && m < ys && n >= -xs && n < xs) begin
                    e.in_image = 1'b1;
                    e.sx = COORD_BITS'(n + xs);
                    e.sy = COORD_BITS'(m + ys);
                end
            end
            pending_sources.push_back(e);
        endfunction

        function void check_field(string name, int expected_v, int actual_v);
            if (expected_v != actual_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, expected_v, actual_v);
            end
        endfunction

        function void compare_source(logic [DATA_W-1:0] data, logic flag);
            source_t e;
            if (pending_sources.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual x %0d y %0d inside %0d",
                         $time, data[COORD_BITS-1:0], data[2*COORD_BITS-1:COORD_BITS], flag);
                return;
            end
            e = pending_sources.pop_front();
            checked++;
            if (e.in_image) inside_seen++;
            check_field("source_x", e.sx, data[COORD_BITS-1:0]);
            check_field("source_y", e.sy, data[2*COORD_BITS-1:COORD_BITS]);
            check_field("inside_res", e.in_image,
                        (flag === 1'b1) ? 1 : ((flag === 1'b0) ? 0 : 2));
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [DATA_W-1:0]             s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [DATA_W-1:0]             m_tdata;
    logic                          m_tuser;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CFG_INDEX_BITS-1:0]     cfg_index;
    logic [ZOOM_BITS-1:0]          cfg_data;

    rotozoom_scoreboard sb = new();
    bit                 stall_on;
    int                 cycle_count;

    rotate_zoom_source_address #(
        .COORD_BITS     (COORD_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.compare_source(m_tdata, m_tuser);
    end

    always begin
        @(posedge aclk);
        if (stall_on && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
            m_tready <= 1'b1;
        end
    end

    task automatic send_destination(input logic [COORD_BITS-1:0] dx,
                                    input logic [COORD_BITS-1:0] dy);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(DATA_W - 2 * COORD_BITS){1'b0}}, dy, dx};
        do @(posedge aclk); while (!s_tready);
        sb.add_destination(dx, dy);
    endtask

    task automatic write_register(input cfg_reg_t idx, input logic [ZOOM_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_register(idx, data);
    endtask

    // Waits for the pipeline to drain, then loads all five registers.
    task automatic configure(input int angle, input int zx, input int zy,
                             input int hw, input int hh, input bit junk);
        s_tvalid <= 1'b0;
        while (sb.pending_sources.size() != 0) @(posedge aclk);
        write_register(CFG_ANGLE, {junk ? 7'($urandom) : 7'd0, 10'(angle)});
        write_register(CFG_ZOOM_X, 17'(zx));
        write_register(CFG_ZOOM_Y, 17'(zy));
        write_register(CFG_HALF_W, {junk ? 7'($urandom) : 7'd0, 10'(hw)});
        write_register(CFG_HALF_H, {junk ? 7'($urandom) : 7'd0, 10'(hh)});
        cfg_valid <= 1'b0;
    endtask

    // Mostly raster order across the image, with some scattered and some off-image pixels.
    task automatic drive_window(input int count, input bit gaps);
        int                    wx;
        int                    wy;
        int                    rx;
        int                    ry;
        int                    pick;
        logic [COORD_BITS-1:0] dx;
        logic [COORD_BITS-1:0] dy;
        wx = (sb.half_w == 0) ? 1 : 2 * int'(sb.half_w);
        wy = (sb.half_h == 0) ? 1 : 2 * int'(sb.half_h);
        rx = $urandom_range(0, wx - 1);
        ry = $urandom_range(0, wy - 1);
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                rx++;
                if (rx >= wx) begin
                    rx = 0;
                    ry = (ry + 1 >= wy) ? 0 : ry + 1;
                end
                dx = COORD_BITS'(rx);
                dy = COORD_BITS'(ry);
            end else if (pick < 9) begin
                dx = COORD_BITS'($urandom_range(0, wx - 1));
                dy = COORD_BITS'($urandom_range(0, wy - 1));
            end else begin
                dx = COORD_BITS'($urandom);
                dy = COORD_BITS'($urandom);
            end
            if (gaps && $urandom_range(0, 4) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
            send_destination(dx, dy);
        end
    endtask

    function automatic int pick_zoom();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 65536;
            2:       return $urandom_range(1, 65536);
            default: return $urandom_range(20000, 65536);
        endcase
    endfunction

    function automatic int pick_half();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 512);
            1:       return 512;
            default: return $urandom_range(4, 320);
        endcase
    endfunction

    initial begin
        int angle;
        bit gaps;
        aclk        = 1'b0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b1;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_ANGLE;
        cfg_data    = '0;
        stall_on    = 1'b0;
        cycle_count = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_destination(0, 0);
        send_destination(1023, 1023);
        send_destination(320, 240);
        send_destination(319, 239);
        send_destination(639, 479);
        send_destination(640, 480);
        configure(90, 0, 65536, 320, 240, 1'b0);
        send_destination(320, 240);
        send_destination(10, 10);
        configure(-90, 65536, 0, 320, 240, 1'b0);
        send_destination(100, 200);
        configure(-360, 65536, 65536, 0, 0, 1'b0);
        send_destination(0, 0);
        send_destination(5, 7);
        configure(511, 1, 1, 512, 512, 1'b0);
        send_destination(0, 0);
        send_destination(512, 512);
        send_destination(1023, 1023);
        configure(-512, 65536, 32768, 1, 1, 1'b0);
        send_destination(0, 0);
        send_destination(1, 1);
        send_destination(1023, 0);
        configure(360, 65536, 65536, 512, 512, 1'b1);
        send_destination(1023, 1023);
        send_destination(0, 0);
        configure(45, 40000, 65535, 64, 32, 1'b0);
        send_destination(63, 31);
        send_destination(127, 63);
        send_destination(128, 64);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(0, 5))
                0: begin
                    angle = 90 * int'($urandom_range(0, 8)) - 360;
                end
                1: begin
                    angle = int'($urandom_range(0, 1023)) - 512;
                end
                default: begin
                    angle = int'($urandom_range(0, 720)) - 360;
                end
            endcase
            gaps     = (p < RANDOM_PHASES - 4) && ($urandom_range(0, 3) != 0);
            stall_on = (p < RANDOM_PHASES - 4) && ($urandom_range(0, 3) != 0);
            configure(angle, pick_zoom(), pick_zoom(), pick_half(), pick_half(),
                      1'($urandom_range(0, 1)));
            drive_window(PHASE_ITEMS, gaps);
        end

        s_tvalid <= 1'b0;
        while (sb.pending_sources.size() != 0) @(posedge aclk);
        repeat (2 * LATENCY) @(posedge aclk);
        $display("Checked %0d source addresses over %0d register settings;", sb.checked,
                 RANDOM_PHASES + 8);
        $display("%0d of them fell inside the image, %0d field errors.", sb.inside_seen,
                 sb.errors);
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
